// ===== design/sbbeh_pkg.sv =====
// Package: types, widths, edge codes and helpers for the swept ball box edge hit test.
`timescale 1ns / 1ps

package sbbeh_pkg;

  // Coordinate and radius widths
  localparam int COORD_WIDTH  = 16;
  localparam int RADIUS_WIDTH = 12;

  // Derived widths
  localparam int GW = COORD_WIDTH + 1;       // grown edge coordinate
  localparam int DW = COORD_WIDTH + 2;       // differences of coordinates
  localparam int PW = 2 * COORD_WIDTH + 2;   // products
  localparam int NW = 2 * COORD_WIDTH + 3;   // sums of products
  localparam int IW = 2 * COORD_WIDTH + 4;   // range test operands
  localparam int QB = COORD_WIDTH + 1;       // quotient magnitude bits

  // Edge codes
  localparam logic [1:0] EDGE_RIGHT  = 2'd0;
  localparam logic [1:0] EDGE_LEFT   = 2'd1;
  localparam logic [1:0] EDGE_BOTTOM = 2'd2;
  localparam logic [1:0] EDGE_TOP    = 2'd3;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0]  ball_x;
    logic signed [COORD_WIDTH-1:0]  ball_y;
    logic signed [COORD_WIDTH-1:0]  step_x;
    logic signed [COORD_WIDTH-1:0]  step_y;
    logic        [RADIUS_WIDTH-1:0] ball_radius;
    logic signed [COORD_WIDTH-1:0]  box_left;
    logic signed [COORD_WIDTH-1:0]  box_top;
    logic signed [COORD_WIDTH-1:0]  box_right;
    logic signed [COORD_WIDTH-1:0]  box_bottom;
  } req_t;

  typedef struct packed {
    logic                          hit;
    logic [1:0]                    edge_res;
    logic signed [COORD_WIDTH-1:0] hit_x;
    logic signed [COORD_WIDTH-1:0] hit_y;
  } res_t;

  // Side information that travels with the divider
  typedef struct packed {
    logic                   hit;
    logic [1:0]             code;
    logic                   vert;
    logic signed [GW-1:0]   coord;
    logic                   neg;
    logic [COORD_WIDTH-1:0] dmag;
  } side_t;

  // Ratio n/d lies in [0,1], bounds inclusive; d is nonzero
  function automatic logic in_unit(input logic signed [IW-1:0] n,
                                   input logic signed [IW-1:0] d);
    logic r;
    if (d > 0) r = (n >= 0) && (n <= d);
    else       r = (n <= 0) && (n >= d);
    return r;
  endfunction

  // Clamp to the signed coordinate range
  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] lo;
    logic signed [COORD_WIDTH-1:0] r;
    hi = DW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    lo = -hi - DW'(1);
    if (v > hi)      r = hi[COORD_WIDTH-1:0];
    else if (v < lo) r = lo[COORD_WIDTH-1:0];
    else             r = v[COORD_WIDTH-1:0];
    return r;
  endfunction

endpackage

// ===== design/swept_ball_box_edge_hit_top.sv =====
// Top level: pipelined swept ball against grown box edge hit test.
//
//  channel  | ports             | handshake
//  ---------+-------------------+-------------------------------------
//  request  | start, busy, req  | taken when start is high, busy low
//  result   | done, res         | done high for one cycle per request
//
// A request enters every cycle; busy is always low.
// The pipeline has four arithmetic stages (grow, differences,
// products, sums and edge select), 17 restoring divider stages (one
// quotient bit each) and an output register.
// Reset clears only the valid bits; the results cannot be stalled.
`timescale 1ns / 1ps

module swept_ball_box_edge_hit_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sbbeh_pkg::req_t   req,
  output logic              done,
  output sbbeh_pkg::res_t   res
);
  import sbbeh_pkg::*;

  localparam int W = COORD_WIDTH;

  assign busy = 1'b0;

  // Stage 1: register inputs, grow the box
  logic v1;
  logic signed [W-1:0]  s1_px, s1_py, s1_vx, s1_vy;
  logic signed [GW-1:0] s1_gl, s1_gt, s1_gr, s1_gb;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
    s1_px <= req.ball_x;
    s1_py <= req.ball_y;
    s1_vx <= req.step_x;
    s1_vy <= req.step_y;
    s1_gl <= GW'(req.box_left)   - $signed(GW'(req.ball_radius));
    s1_gt <= GW'(req.box_top)    - $signed(GW'(req.ball_radius));
    s1_gr <= GW'(req.box_right)  + $signed(GW'(req.ball_radius));
    s1_gb <= GW'(req.box_bottom) + $signed(GW'(req.ball_radius));
  end

  // Stage 2: coordinate differences
  logic v2;
  logic signed [W-1:0]  s2_px, s2_py, s2_vx, s2_vy;
  logic signed [GW-1:0] s2_gl, s2_gt, s2_gr, s2_gb;
  logic signed [DW-1:0] s2_ar, s2_al, s2_bb, s2_bt, s2_ey, s2_ex;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    s2_px <= s1_px;
    s2_py <= s1_py;
    s2_vx <= s1_vx;
    s2_vy <= s1_vy;
    s2_gl <= s1_gl;
    s2_gt <= s1_gt;
    s2_gr <= s1_gr;
    s2_gb <= s1_gb;
    s2_ar <= DW'(s1_px) - DW'(s1_gr);
    s2_al <= DW'(s1_px) - DW'(s1_gl);
    s2_bb <= DW'(s1_py) - DW'(s1_gb);
    s2_bt <= DW'(s1_py) - DW'(s1_gt);
    s2_ey <= DW'(s1_gb) - DW'(s1_gt);
    s2_ex <= DW'(s1_gr) - DW'(s1_gl);
  end

  // Stage 3: products, path parameter tests, nonzero denominators
  logic v3;
  logic signed [W-1:0]  s3_vx, s3_vy;
  logic signed [GW-1:0] s3_gl, s3_gt, s3_gr, s3_gb;
  logic signed [PW-1:0] p_vxbt, p_vyar, p_vyal, p_vxbb, p_eyvx, p_exvy, p_pyvx, p_pxvy;
  logic ua_r, ua_l, ua_b, ua_t, dn_v, dn_h;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    s3_vx  <= s2_vx;
    s3_vy  <= s2_vy;
    s3_gl  <= s2_gl;
    s3_gt  <= s2_gt;
    s3_gr  <= s2_gr;
    s3_gb  <= s2_gb;
    p_vxbt <= PW'(s2_vx) * PW'(s2_bt);
    p_vyar <= PW'(s2_vy) * PW'(s2_ar);
    p_vyal <= PW'(s2_vy) * PW'(s2_al);
    p_vxbb <= PW'(s2_vx) * PW'(s2_bb);
    p_eyvx <= PW'(s2_ey) * PW'(s2_vx);
    p_exvy <= PW'(s2_ex) * PW'(s2_vy);
    p_pyvx <= PW'(s2_py) * PW'(s2_vx);
    p_pxvy <= PW'(s2_px) * PW'(s2_vy);
    ua_r   <= in_unit(-IW'(s2_ar), IW'(s2_vx));
    ua_l   <= in_unit(-IW'(s2_al), IW'(s2_vx));
    ua_b   <= in_unit(-IW'(s2_bb), IW'(s2_vy));
    ua_t   <= in_unit(-IW'(s2_bt), IW'(s2_vy));
    dn_v   <= (s2_vx != '0) && (s2_ey != '0);
    dn_h   <= (s2_vy != '0) && (s2_ex != '0);
  end

  // Stage 4: edge parameter sums, priority edge select, divider operands
  logic signed [NW-1:0] nb_r, nb_l, nb_b, nb_t, den_h, n_sel;
  logic signed [W-1:0]  d_sel;
  logic h_r, h_l, h_b, h_t;
  side_t side_next;

  always_comb begin
    nb_r  = NW'(p_vxbt) - NW'(p_vyar);
    nb_l  = NW'(p_vxbt) - NW'(p_vyal);
    nb_b  = NW'(p_vxbb) - NW'(p_vyal);
    nb_t  = NW'(p_vxbt) - NW'(p_vyal);
    den_h = -NW'(p_exvy);
    h_r = dn_v && ua_r && in_unit(IW'(nb_r), IW'(p_eyvx));
    h_l = dn_v && ua_l && in_unit(IW'(nb_l), IW'(p_eyvx));
    h_b = dn_h && ua_b && in_unit(IW'(nb_b), IW'(den_h));
    h_t = dn_h && ua_t && in_unit(IW'(nb_t), IW'(den_h));
    side_next.hit = h_r || h_l || h_b || h_t;
    // pick one hit edge in fixed priority order: right, left, bottom, top
    if (h_r) begin
      side_next.code  = EDGE_RIGHT;
      side_next.vert  = 1'b1;
      side_next.coord = s3_gr;
      n_sel = NW'(p_pyvx) - NW'(p_vyar);
    end else if (h_l) begin
      side_next.code  = EDGE_LEFT;
      side_next.vert  = 1'b1;
      side_next.coord = s3_gl;
      n_sel = NW'(p_pyvx) - NW'(p_vyal);
    end else if (h_b) begin
      side_next.code  = EDGE_BOTTOM;
      side_next.vert  = 1'b0;
      side_next.coord = s3_gb;
      n_sel = NW'(p_pxvy) - NW'(p_vxbb);
    end else begin
      side_next.code  = EDGE_TOP;
      side_next.vert  = 1'b0;
      side_next.coord = s3_gt;
      n_sel = NW'(p_pxvy) - NW'(p_vxbt);
    end
    d_sel = side_next.vert ? s3_vx : s3_vy;
    side_next.neg  = n_sel[NW-1] ^ d_sel[W-1];
    side_next.dmag = d_sel[W-1] ? W'(-d_sel) : W'(d_sel);
  end

  // Divider pipeline: index 0 is the stage 4 register
  logic              dv   [QB+1];
  side_t             sd   [QB+1];
  logic [W:0]        rem  [QB+1];
  logic [QB-1:0]     dl   [QB+1];
  logic [QB-1:0]     quo  [QB+1];
  logic [NW-1:0]     nmag;

  assign nmag = n_sel[NW-1] ? NW'(-n_sel) : NW'(n_sel);

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else     dv[0] <= v3;
    sd[0]  <= side_next;
    rem[0] <= nmag[QB+W:QB];
    dl[0]  <= nmag[QB-1:0];
    quo[0] <= '0;
  end

  // One quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [W+1:0] t;
    logic         ge;
    logic [W+1:0] diff;
    always_comb begin
      t    = {rem[k], dl[k][QB-1]};
      ge   = t >= {2'b00, sd[k].dmag};
      diff = t - {2'b00, sd[k].dmag};
    end
    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else     dv[k+1] <= dv[k];
      sd[k+1]  <= sd[k];
      rem[k+1] <= ge ? diff[W:0] : t[W:0];
      dl[k+1]  <= dl[k] << 1;
      quo[k+1] <= {quo[k][QB-2:0], ge};
    end
  end

  // Output: sign, saturate, zero on no hit
  logic signed [DW-1:0] qv;
  logic signed [W-1:0]  qs, cs;
  res_t res_next;

  always_comb begin
    qv = sd[QB].neg ? -DW'({1'b0, quo[QB]}) : DW'({1'b0, quo[QB]});
    qs = sat(qv);
    cs = sat(DW'(sd[QB].coord));
    res_next.hit      = sd[QB].hit;
    res_next.edge_res = sd[QB].hit ? sd[QB].code : 2'd0;
    res_next.hit_x    = '0;
    res_next.hit_y    = '0;
    if (sd[QB].hit) begin
      res_next.hit_x = sd[QB].vert ? cs : qs;
      res_next.hit_y = sd[QB].vert ? qs : cs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv[QB];
    res <= res_next;
  end

endmodule
